/* sv/per_key_request_serializer_defines.svh */
// Assertion macros for the per-key request serializer.
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef PER_KEY_REQUEST_SERIALIZER_DEFINES_SVH
`define PER_KEY_REQUEST_SERIALIZER_DEFINES_SVH

`ifndef ASSERT_OFF
`define PKS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pks assertion failed");
`define PKS_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("pks forbidden condition");
`else
`define PKS_ASSERT(label, clk, rst, prop)
`define PKS_ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

/* sv/pks_pkg.sv */
// Shared types, codes and constants of the per-key request serializer.
// No dependencies.
`timescale 1ns / 1ps

package pks_pkg;

  localparam int NUM_BARRIERS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF  = 8;

  localparam int KEY_W     = 64;
  localparam int TAG_W     = 8;
  localparam int ACT_W     = 3;
  localparam int STAT_W    = 2;
  localparam int MAXB_W    = 5;
  localparam int MAXK_W    = 4;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [MAXB_W-1:0] MAXB_RESET = MAXB_W'(16);
  localparam logic [MAXK_W-1:0] MAXK_RESET = MAXK_W'(8);

  typedef enum logic [ACT_W-1:0] {
    ACT_FORWARD,
    ACT_HELD,
    ACT_KEY_FULL,
    ACT_BAR_FULL,
    ACT_RELEASE,
    ACT_ANSWER
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK,
    ST_NO_BARRIER,
    ST_NOT_HEAD
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_BARRIERS,
    REG_MAX_PER_KEY
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_DECIDE,
    S_HEAD,
    S_NEXT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [MAXB_W-1:0] max_barriers;
    logic [MAXK_W-1:0] max_per_key;
  } cfg_t;

  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  function automatic int max_w(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

/* sv/pks_ram.sv */
// Simple dual-port memory: one write port, one read port with registered data.
// Used for the barrier entry table and the job tag queues; no dependencies.
`timescale 1ns / 1ps

module pks_ram #(
  parameter int AW = 4,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* sv/pks_ctrl.sv */
// Sequencer of the per-key request serializer: table scan with one shared key
// comparator, queue update and result register. Depends on pks_pkg.
`timescale 1ns / 1ps

module pks_ctrl import pks_pkg::*; #(
  parameter int NUM_BARRIERS = NUM_BARRIERS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  localparam int IW  = idx_w(NUM_BARRIERS),
  localparam int QW  = idx_w(QUEUE_DEPTH),
  localparam int FW  = $clog2(QUEUE_DEPTH + 1),
  localparam int EW  = KEY_W + QW + FW,
  localparam int TAW = IW + QW
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              opcode,
  input  logic              bypass,
  input  logic [KEY_W-1:0]  key,
  input  logic [TAG_W-1:0]  job_tag,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ACT_W-1:0]  action,
  output logic [TAG_W-1:0]  out_tag,
  output logic [STAT_W-1:0] answer_status,
  output logic              last,
  output logic              ent_we,
  output logic [IW-1:0]     ent_waddr,
  output logic [EW-1:0]     ent_wdata,
  output logic [IW-1:0]     ent_raddr,
  input  logic [EW-1:0]     ent_rdata,
  output logic              tag_we,
  output logic [TAW-1:0]    tag_waddr,
  output logic [TAG_W-1:0]  tag_wdata,
  output logic [TAW-1:0]    tag_raddr,
  input  logic [TAG_W-1:0]  tag_rdata
);

  localparam int AC = $clog2(NUM_BARRIERS + 1);
  localparam int MW = max_w(AC, MAXB_W);
  localparam int LW = max_w(FW, MAXK_W);
  localparam int SW = max_w(QW, FW) + 1;

  state_t             state, state_next;
  logic               op_r, op_r_next;
  logic [KEY_W-1:0]   key_r, key_r_next;
  logic [TAG_W-1:0]   tag_r, tag_r_next;
  logic [IW-1:0]      idx, idx_next;
  logic               found, found_next;
  logic [IW-1:0]      ent_idx, ent_idx_next;
  logic [QW-1:0]      ent_head, ent_head_next;
  logic [FW-1:0]      ent_fill, ent_fill_next;
  logic               free_found, free_found_next;
  logic [IW-1:0]      free_idx, free_idx_next;
  logic [NUM_BARRIERS-1:0] valid, valid_next;
  logic [AC-1:0]      active, active_next;
  action_t            res_action, res_action_next;
  logic [TAG_W-1:0]   res_tag, res_tag_next;
  status_t            res_status, res_status_next;
  logic               res_last, res_last_next;
  logic               second, second_next;
  logic               out_valid_next;
  action_t            out_action, out_action_next;
  logic [TAG_W-1:0]   out_tag_next;
  status_t            out_status, out_status_next;
  logic               last_next;

  logic [KEY_W-1:0]   rd_key;
  logic [QW-1:0]      rd_head;
  logic [FW-1:0]      rd_fill;
  logic               key_hit;
  logic               fill_ok;
  logic               bar_full;
  logic [SW-1:0]      slot_sum;
  logic [SW-1:0]      slot_wrap;
  logic [QW-1:0]      push_slot;
  logic [QW-1:0]      head_inc;
  logic               emit_ok;

  assign rd_key  = ent_rdata[EW-1 -: KEY_W];
  assign rd_head = ent_rdata[FW +: QW];
  assign rd_fill = ent_rdata[FW-1:0];

  // shared comparator: one stored key against the held key per iteration
  assign key_hit = valid[idx] && (rd_key == key_r);

  assign fill_ok  = (LW'(ent_fill) < LW'(cfg.max_per_key)) &&
                    (ent_fill < FW'(QUEUE_DEPTH));
  assign bar_full = MW'(active) >= MW'(cfg.max_barriers);

  assign slot_sum  = SW'(ent_head) + SW'(ent_fill);
  assign slot_wrap = (slot_sum >= SW'(QUEUE_DEPTH)) ? slot_sum - SW'(QUEUE_DEPTH)
                                                    : slot_sum;
  assign push_slot = slot_wrap[QW-1:0];
  assign head_inc  = (ent_head == QW'(QUEUE_DEPTH - 1)) ? '0 : ent_head + QW'(1);

  assign emit_ok = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      active    <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      valid     <= valid_next;
      active    <= active_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_r_next;
    key_r      <= key_r_next;
    tag_r      <= tag_r_next;
    idx        <= idx_next;
    found      <= found_next;
    ent_idx    <= ent_idx_next;
    ent_head   <= ent_head_next;
    ent_fill   <= ent_fill_next;
    free_found <= free_found_next;
    free_idx   <= free_idx_next;
    res_action <= res_action_next;
    res_tag    <= res_tag_next;
    res_status <= res_status_next;
    res_last   <= res_last_next;
    second     <= second_next;
    out_action <= out_action_next;
    out_tag    <= out_tag_next;
    out_status <= out_status_next;
    last       <= last_next;
  end

  always_comb begin
    state_next      = state;
    op_r_next       = op_r;
    key_r_next      = key_r;
    tag_r_next      = tag_r;
    idx_next        = idx;
    found_next      = found;
    ent_idx_next    = ent_idx;
    ent_head_next   = ent_head;
    ent_fill_next   = ent_fill;
    free_found_next = free_found;
    free_idx_next   = free_idx;
    valid_next      = valid;
    active_next     = active;
    res_action_next = res_action;
    res_tag_next    = res_tag;
    res_status_next = res_status;
    res_last_next   = res_last;
    second_next     = second;
    out_valid_next  = out_valid && !out_ready;
    out_action_next = out_action;
    out_tag_next    = out_tag;
    out_status_next = out_status;
    last_next       = last;

    in_ready  = 1'b0;
    ent_we    = 1'b0;
    ent_waddr = ent_idx;
    ent_wdata = {key_r, ent_head, ent_fill};
    ent_raddr = idx;
    tag_we    = 1'b0;
    tag_waddr = {ent_idx, push_slot};
    tag_wdata = tag_r;
    tag_raddr = {ent_idx, ent_head};

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_r_next       = opcode;
          key_r_next      = key;
          tag_r_next      = job_tag;
          idx_next        = '0;
          found_next      = 1'b0;
          free_found_next = 1'b0;
          res_tag_next    = job_tag;
          res_status_next = ST_OK;
          res_last_next   = 1'b1;
          second_next     = 1'b0;
          if (bypass) begin
            res_action_next = opcode ? ACT_ANSWER : ACT_FORWARD;
            state_next      = S_EMIT;
          end else begin
            state_next = S_READ;
          end
        end
      end

      S_READ: begin
        if (!valid[idx] && !free_found) begin
          free_found_next = 1'b1;
          free_idx_next   = idx;
        end
        state_next = S_CMP;
      end

      S_CMP: begin
        if (key_hit) begin
          found_next    = 1'b1;
          ent_idx_next  = idx;
          ent_head_next = rd_head;
          ent_fill_next = rd_fill;
          state_next    = S_DECIDE;
        end else if (idx == IW'(NUM_BARRIERS - 1)) begin
          state_next = S_DECIDE;
        end else begin
          idx_next   = idx + IW'(1);
          state_next = S_READ;
        end
      end

      S_DECIDE: begin
        state_next = S_EMIT;
        if (!op_r) begin
          if (found) begin
            if (fill_ok) begin
              tag_we          = 1'b1;
              ent_we          = 1'b1;
              ent_wdata       = {key_r, ent_head, ent_fill + FW'(1)};
              res_action_next = ACT_HELD;
            end else begin
              res_action_next = ACT_KEY_FULL;
            end
          end else if (bar_full || !free_found) begin
            res_action_next = ACT_BAR_FULL;
          end else begin
            valid_next[free_idx] = 1'b1;
            ent_we          = 1'b1;
            ent_waddr       = free_idx;
            ent_wdata       = {key_r, QW'(0), FW'(1)};
            tag_we          = 1'b1;
            tag_waddr       = {free_idx, QW'(0)};
            active_next     = active + AC'(1);
            res_action_next = ACT_FORWARD;
          end
        end else begin
          res_action_next = ACT_ANSWER;
          if (!found) begin
            res_status_next = ST_NO_BARRIER;
          end else if (ent_fill == '0) begin
            res_status_next = ST_NOT_HEAD;
          end else begin
            state_next = S_HEAD;
          end
        end
      end

      S_HEAD: begin
        state_next = S_EMIT;
        if (tag_rdata != tag_r) begin
          res_status_next = ST_NOT_HEAD;
        end else begin
          ent_we    = 1'b1;
          ent_wdata = {key_r, head_inc, ent_fill - FW'(1)};
          if (ent_fill == FW'(1)) begin
            valid_next[ent_idx] = 1'b0;
            if (active != '0) begin
              active_next = active - AC'(1);
            end
          end else begin
            tag_raddr  = {ent_idx, head_inc};
            state_next = S_NEXT;
          end
        end
      end

      S_NEXT: begin
        res_action_next = ACT_RELEASE;
        res_tag_next    = tag_rdata;
        res_status_next = ST_OK;
        res_last_next   = 1'b0;
        second_next     = 1'b1;
        state_next      = S_EMIT;
      end

      S_EMIT: begin
        if (emit_ok) begin
          out_valid_next  = 1'b1;
          out_action_next = res_action;
          out_tag_next    = res_tag;
          out_status_next = res_status;
          last_next       = res_last;
          if (second) begin
            res_action_next = ACT_ANSWER;
            res_tag_next    = tag_r;
            res_status_next = ST_OK;
            res_last_next   = 1'b1;
            second_next     = 1'b0;
          end else begin
            state_next = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign action        = out_action;
  assign answer_status = out_status;

endmodule

/* sv/per_key_request_serializer.sv */
// Per-key request serializer. A request or answer with bypass set goes straight
// to the result; a keyed item scans the barrier table through the single read
// port of the entry memory, with a read state and a compare state per entry,
// stopping at the key match, and then decides in S_DECIDE; an answer that
// reaches its queue head passes S_HEAD and, when it releases the next waiting
// job, S_NEXT. An answer that releases the next waiting job gives two results,
// release then answer. The input accepts a new item only once all results of
// the previous one sit in or have left the output register. No clearing pass
// runs after reset.
`timescale 1ns / 1ps
`include "per_key_request_serializer_defines.svh"

module per_key_request_serializer import pks_pkg::*; #(
  parameter int NUM_BARRIERS = NUM_BARRIERS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 opcode,
  input  logic                 bypass,
  input  logic [KEY_W-1:0]     key,
  input  logic [TAG_W-1:0]     job_tag,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ACT_W-1:0]     action,
  output logic [TAG_W-1:0]     out_tag,
  output logic [STAT_W-1:0]    answer_status,
  output logic                 last
);

  localparam int IW  = idx_w(NUM_BARRIERS);
  localparam int QW  = idx_w(QUEUE_DEPTH);
  localparam int FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int EW  = KEY_W + QW + FW;
  localparam int TAW = IW + QW;

  cfg_t cfg;

  logic             ent_we;
  logic [IW-1:0]    ent_waddr;
  logic [EW-1:0]    ent_wdata;
  logic [IW-1:0]    ent_raddr;
  logic [EW-1:0]    ent_rdata;
  logic             tag_we;
  logic [TAW-1:0]   tag_waddr;
  logic [TAG_W-1:0] tag_wdata;
  logic [TAW-1:0]   tag_raddr;
  logic [TAG_W-1:0] tag_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_barriers <= MAXB_RESET;
      cfg.max_per_key  <= MAXK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MAX_BARRIERS: cfg.max_barriers <= cfg_data[MAXB_W-1:0];
        REG_MAX_PER_KEY:  cfg.max_per_key  <= cfg_data[MAXK_W-1:0];
        default: ;
      endcase
    end
  end

  pks_ram #(
    .AW (IW),
    .DW (EW)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  pks_ram #(
    .AW (TAW),
    .DW (TAG_W)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  pks_ctrl #(
    .NUM_BARRIERS (NUM_BARRIERS),
    .QUEUE_DEPTH  (QUEUE_DEPTH)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .bypass        (bypass),
    .key           (key),
    .job_tag       (job_tag),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .action        (action),
    .out_tag       (out_tag),
    .answer_status (answer_status),
    .last          (last),
    .ent_we        (ent_we),
    .ent_waddr     (ent_waddr),
    .ent_wdata     (ent_wdata),
    .ent_raddr     (ent_raddr),
    .ent_rdata     (ent_rdata),
    .tag_we        (tag_we),
    .tag_waddr     (tag_waddr),
    .tag_wdata     (tag_wdata),
    .tag_raddr     (tag_raddr),
    .tag_rdata     (tag_rdata)
  );

  `PKS_ASSERT(a_busy_after_accept, clk, rst, in_valid && in_ready |=> !in_ready)
  `PKS_ASSERT_NEVER(a_release_not_last, clk, rst, out_valid && action == ACT_RELEASE && last)
  `PKS_ASSERT(a_status_on_answer, clk, rst, out_valid && answer_status != ST_OK |-> action == ACT_ANSWER)

endmodule
